// ===== hdl/hsi_pkg.sv =====
// hsi_pkg: shared widths, register codes, pipeline structs and the cosine table builder
// for the HSI colour-scale mapper. No dependencies; compiled before every other file.
package hsi_pkg;

    localparam int FRAC_BITS  = 12;
    localparam int ONE        = 1 << FRAC_BITS;
    localparam int SIX        = 6 * ONE;
    localparam int HUE_W      = 15;
    localparam int LVL_W      = 13;
    localparam int SPAN_W     = 14;
    localparam int POS_W      = 16;
    localparam int BYTE_W     = 8;
    localparam int BYTE_MAX   = (1 << BYTE_W) - 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int HSUM_W     = 16;                // hue after the single wrap
    localparam int PHASE_W    = $clog2(SIX);       // channel phase, below SIX
    localparam int SI_W       = 16;                // interpolated sat / intensity
    localparam int PURE_W     = FRAC_BITS + 1;

    localparam int INTERP_STAGES = 2;
    localparam int CHAN_STAGES   = 5;
    localparam int STAGES        = INTERP_STAGES + CHAN_STAGES;

    localparam longint Q30    = longint'(1) << 30;
    localparam longint PI_Q30 = 64'sd3373259426;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_HUE = 3'd0,
        REG_START_SAT = 3'd1,
        REG_START_INT = 3'd2,
        REG_HUE_SPAN  = 3'd3,
        REG_SAT_SPAN  = 3'd4,
        REG_INT_SPAN  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic        [HUE_W-1:0]  start_hue;
        logic        [LVL_W-1:0]  start_sat;
        logic        [LVL_W-1:0]  start_int;
        logic        [HUE_W-1:0]  hue_span;
        logic signed [SPAN_W-1:0] sat_span;
        logic signed [SPAN_W-1:0] int_span;
    } t_hsi_cfg;

    typedef struct packed {
        logic        [HSUM_W-1:0] hue;
        logic signed [SI_W-1:0]   sat;
        logic signed [SI_W-1:0]   inten;
    } t_hsi_pix;

    // per-stage load enables, stage 0 in the lsb
    typedef struct packed {
        logic [CHAN_STAGES-1:0]   chan;
        logic [INTERP_STAGES-1:0] interp;
    } t_pipe_en;

    // one series step: term * x^2 in Q30, truncating
    function automatic longint series_mul(longint term, longint x2);
        return (term * x2) / Q30;
    endfunction

    // cosine on 0..pi/2 in Q30 by an eleven-term series, truncating division
    function automatic longint cos_q30(longint x);
        longint x2;
        longint term;
        longint sum;
        x2   = (x * x) >>> 30;
        term = Q30;
        sum  = Q30;
        term = -series_mul(term, x2) / 64'sd2;
        sum  = sum + term;
        term = -series_mul(term, x2) / 64'sd12;
        sum  = sum + term;
        term = -series_mul(term, x2) / 64'sd30;
        sum  = sum + term;
        term = -series_mul(term, x2) / 64'sd56;
        sum  = sum + term;
        term = -series_mul(term, x2) / 64'sd90;
        sum  = sum + term;
        term = -series_mul(term, x2) / 64'sd132;
        sum  = sum + term;
        term = -series_mul(term, x2) / 64'sd182;
        sum  = sum + term;
        term = -series_mul(term, x2) / 64'sd240;
        sum  = sum + term;
        term = -series_mul(term, x2) / 64'sd306;
        sum  = sum + term;
        term = -series_mul(term, x2) / 64'sd380;
        sum  = sum + term;
        return sum;
    endfunction

    // 0.5*(1+cos(x)) for x in 0..pi (Q30), rounded to FRAC_BITS, clamped to 0..ONE
    function automatic logic [PURE_W-1:0] pure_entry(longint x);
        longint c;
        longint p;
        if (2 * x > PI_Q30)
            c = -cos_q30(PI_Q30 - x);
        else
            c = cos_q30(x);
        p = (Q30 + c) / 2;
        p = (p + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        if (p < 0)
            p = 0;
        if (p > longint'(ONE))
            p = longint'(ONE);
        return PURE_W'(p);
    endfunction

endpackage

// ===== hdl/hsi_if.sv =====
// Stream and configuration interfaces of the HSI colour-scale mapper.
// Depends on hsi_pkg for the field widths.
interface hsi_pos_if;
    import hsi_pkg::*;
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] position;
    modport source (output valid, output position, input ready);
    modport sink (input valid, input position, output ready);
endinterface

interface hsi_rgb_if;
    import hsi_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    modport source (output valid, output red, output green, output blue, input ready);
    modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface hsi_cfg_if;
    import hsi_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output idx, output data, input ready);
    modport sink (input valid, input idx, input data, output ready);
endinterface

// ===== hdl/hsi_interp.sv =====
// hsi_interp: two-stage linear interpolation of hue, saturation and intensity
// along the scale, with the single hue wrap. Depends on hsi_pkg.
module hsi_interp (
    input  logic                         i_clk,
    input  hsi_pkg::t_pipe_en            i_en,
    input  hsi_pkg::t_hsi_cfg            i_cfg,
    input  logic [hsi_pkg::POS_W-1:0]    i_position,
    output hsi_pkg::t_hsi_pix            o_pix
);
    import hsi_pkg::*;

    localparam int HPROD_W = HUE_W + POS_W;
    localparam int SPROD_W = SPAN_W + POS_W + 1;

    logic        [HPROD_W-1:0] r_hue_prod;
    logic signed [SPROD_W-1:0] r_sat_prod;
    logic signed [SPROD_W-1:0] r_int_prod;
    t_hsi_pix                  r_pix;
    t_hsi_pix                  n_pix;
    logic        [HSUM_W-1:0]  hue_sum;

    always_ff @(posedge i_clk) begin
        if (i_en.interp[0]) begin
            r_hue_prod <= HPROD_W'(i_cfg.hue_span) * HPROD_W'(i_position);
            r_sat_prod <= $signed(SPROD_W'(i_cfg.sat_span))
                        * $signed(SPROD_W'({1'b0, i_position}));
            r_int_prod <= $signed(SPROD_W'(i_cfg.int_span))
                        * $signed(SPROD_W'({1'b0, i_position}));
        end
    end

    // arithmetic shift gives floor for negative spans
    always_comb begin
        hue_sum   = HSUM_W'(i_cfg.start_hue) + HSUM_W'(r_hue_prod[HPROD_W-1:POS_W]);
        n_pix.hue = (hue_sum >= HSUM_W'(SIX)) ? hue_sum - HSUM_W'(SIX) : hue_sum;
        n_pix.sat = $signed(SI_W'(i_cfg.start_sat)) + SI_W'(r_sat_prod >>> POS_W);
        n_pix.inten = $signed(SI_W'(i_cfg.start_int)) + SI_W'(r_int_prod >>> POS_W);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.interp[1]) begin
            r_pix <= n_pix;
        end
    end

    assign o_pix = r_pix;

endmodule

// ===== hdl/hsi_chan.sv =====
// hsi_chan: five-stage pipeline for one RGB channel: phase, cosine table lookup,
// saturation blend, intensity scale and byte saturation. Depends on hsi_pkg.
module hsi_chan #(
    parameter int COS_ENTRIES  = 1024,
    parameter int PHASE_SIXTHS = 0
) (
    input  logic                          i_clk,
    input  hsi_pkg::t_pipe_en             i_en,
    input  hsi_pkg::t_hsi_pix             i_pix,
    output logic [hsi_pkg::BYTE_W-1:0]    o_byte
);
    import hsi_pkg::*;

    localparam int IDX_W    = $clog2(COS_ENTRIES);
    localparam int NUM_W    = $clog2(COS_ENTRIES + 1);
    localparam int PSUM_W   = HSUM_W + 1;
    localparam int QP_W     = PHASE_W + NUM_W;
    localparam int SIX_SH   = FRAC_BITS + 1;         // SIX = 3 << SIX_SH
    localparam int Q_W      = QP_W - SIX_SH;
    localparam int RECIP_SH = 17;
    localparam int RECIP3   = 43691;                 // ceil(2^17 / 3)
    localparam int R_W      = Q_W + RECIP_SH;
    localparam int TP_W     = SI_W + PURE_W + 1;
    localparam int T_W      = TP_W - FRAC_BITS;
    localparam int W_W      = SI_W + T_W;
    localparam int X_W      = W_W + BYTE_W;
    localparam longint ROM_N = longint'(COS_ENTRIES);

    typedef logic [PURE_W-1:0] t_pure_rom [COS_ENTRIES];

    // entries past the half turn mirror the first half
    function automatic t_pure_rom build_rom();
        t_pure_rom rom;
        longint    m;
        for (int k = 0; k < COS_ENTRIES; k++) begin
            m = longint'(k);
            if (2 * m > ROM_N)
                m = ROM_N - m;
            rom[k] = pure_entry((2 * PI_Q30 * m) / ROM_N);
        end
        return rom;
    endfunction

    localparam t_pure_rom PURE_ROM = build_rom();

    // stage C
    logic        [PSUM_W-1:0]  phase_sum;
    logic        [PHASE_W-1:0] phase;
    logic        [QP_W-1:0]    r_qprod;
    logic signed [SI_W-1:0]    r_sat_c;
    logic signed [SI_W-1:0]    r_int_c;
    // stage D
    logic        [R_W-1:0]     rprod;
    logic        [IDX_W-1:0]   idx;
    logic        [PURE_W-1:0]  r_pure;
    logic signed [SI_W-1:0]    r_sat_d;
    logic signed [SI_W-1:0]    r_int_d;
    // stage E
    logic signed [TP_W-1:0]    r_tprod;
    logic signed [SI_W-1:0]    r_int_e;
    // stage F
    logic signed [T_W-1:0]     t_val;
    logic signed [T_W-1:0]     u_val;
    logic signed [W_W-1:0]     r_wprod;
    // stage G
    logic signed [X_W-1:0]     w_val;
    logic signed [X_W-1:0]     w_top;
    logic        [BYTE_W-1:0]  n_byte;
    logic        [BYTE_W-1:0]  r_byte;

    // phase below 3*SIX, so two compares bring it into 0..SIX-1
    always_comb begin
        phase_sum = PSUM_W'(i_pix.hue) + PSUM_W'(PHASE_SIXTHS * ONE);
        if (phase_sum >= PSUM_W'(2 * SIX))
            phase = PHASE_W'(phase_sum - PSUM_W'(2 * SIX));
        else if (phase_sum >= PSUM_W'(SIX))
            phase = PHASE_W'(phase_sum - PSUM_W'(SIX));
        else
            phase = PHASE_W'(phase_sum);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.chan[0]) begin
            r_qprod <= QP_W'(phase) * QP_W'(COS_ENTRIES);
            r_sat_c <= i_pix.sat;
            r_int_c <= i_pix.inten;
        end
    end

    // divide by SIX: shift out the power of two, then reciprocal of three
    always_comb begin
        rprod = R_W'(r_qprod[QP_W-1:SIX_SH]) * R_W'(RECIP3);
        idx   = rprod[RECIP_SH +: IDX_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.chan[1]) begin
            r_pure  <= PURE_ROM[idx];
            r_sat_d <= r_sat_c;
            r_int_d <= r_int_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.chan[2]) begin
            r_tprod <= $signed(TP_W'(r_sat_d))
                     * $signed(TP_W'({1'b0, PURE_W'(ONE) - r_pure}));
            r_int_e <= r_int_d;
        end
    end

    always_comb begin
        t_val = T_W'(r_tprod >>> FRAC_BITS);
        u_val = $signed(T_W'(ONE)) - t_val;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.chan[3]) begin
            r_wprod <= $signed(W_W'(r_int_e)) * $signed(W_W'(u_val));
        end
    end

    // times 255, then saturate to a byte
    always_comb begin
        w_val = ($signed(X_W'(r_wprod)) <<< BYTE_W) - $signed(X_W'(r_wprod));
        w_top = w_val >>> (2 * FRAC_BITS);
        if (w_val <= 0)
            n_byte = '0;
        else if (w_top > $signed(X_W'(BYTE_MAX)))
            n_byte = BYTE_W'(BYTE_MAX);
        else
            n_byte = w_top[BYTE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.chan[4]) begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

// ===== hdl/hsi_scale_to_rgb.sv =====
// hsi_scale_to_rgb: top level of the HSI colour-scale mapper, configuration registers,
// pipeline valid and stall control. Depends on hsi_pkg, hsi_if, hsi_interp and hsi_chan.
//
// One scale position per transaction gives one RGB byte triple. The block takes a new
// position every clock unless a stall reaches the input, and each result leaves in order of
// acceptance. Two stages interpolate hue, saturation and intensity, then each colour
// channel runs five stages of its own with a private COS_ENTRIES-entry cosine ROM, so
// the three table reads happen in the same cycle. Stalls propagate stage by stage: an
// empty stage keeps accepting while a finished result waits at the output. The
// configuration port is always ready; write it only while no transaction is in flight.
module hsi_scale_to_rgb #(
    parameter int COS_ENTRIES = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hsi_cfg_if.sink   i_cfg,
    hsi_pos_if.sink   i_pos,
    hsi_rgb_if.source o_rgb
);
    import hsi_pkg::*;

    localparam t_hsi_cfg CFG_RESET = '{
        start_hue: '0,
        start_sat: LVL_W'(ONE),
        start_int: LVL_W'(ONE),
        hue_span:  '0,
        sat_span:  '0,
        int_span:  '0
    };

    t_hsi_cfg          r_cfg;
    logic              cfg_write;
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_vld;
    logic [STAGES-1:0] en_vec;
    t_pipe_en          pipe_en;
    t_hsi_pix          pix;

    assign i_cfg.ready = 1'b1;
    assign cfg_write   = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (cfg_write) begin
            unique case (t_reg_idx'(i_cfg.idx))
                REG_START_HUE: r_cfg.start_hue <= i_cfg.data[HUE_W-1:0];
                REG_START_SAT: r_cfg.start_sat <= i_cfg.data[LVL_W-1:0];
                REG_START_INT: r_cfg.start_int <= i_cfg.data[LVL_W-1:0];
                REG_HUE_SPAN:  r_cfg.hue_span  <= i_cfg.data[HUE_W-1:0];
                REG_SAT_SPAN:  r_cfg.sat_span  <= $signed(i_cfg.data[SPAN_W-1:0]);
                REG_INT_SPAN:  r_cfg.int_span  <= $signed(i_cfg.data[SPAN_W-1:0]);
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or the one after it moves on
    always_comb begin
        en_vec[STAGES-1] = !r_vld[STAGES-1] || o_rgb.ready;
        for (int k = STAGES - 2; k >= 0; k--)
            en_vec[k] = !r_vld[k] || en_vec[k+1];
    end

    assign pipe_en = t_pipe_en'(en_vec);
    assign n_vld   = {r_vld[STAGES-2:0], i_pos.valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (n_vld & en_vec) | (r_vld & ~en_vec);
        end
    end

    assign i_pos.ready = en_vec[0];
    assign o_rgb.valid = r_vld[STAGES-1];

    hsi_interp u_interp (
        .i_clk      (i_clk),
        .i_en       (pipe_en),
        .i_cfg      (r_cfg),
        .i_position (i_pos.position),
        .o_pix      (pix)
    );

    hsi_chan #(.COS_ENTRIES(COS_ENTRIES), .PHASE_SIXTHS(0)) u_red (
        .i_clk  (i_clk),
        .i_en   (pipe_en),
        .i_pix  (pix),
        .o_byte (o_rgb.red)
    );

    hsi_chan #(.COS_ENTRIES(COS_ENTRIES), .PHASE_SIXTHS(4)) u_green (
        .i_clk  (i_clk),
        .i_en   (pipe_en),
        .i_pix  (pix),
        .o_byte (o_rgb.green)
    );

    hsi_chan #(.COS_ENTRIES(COS_ENTRIES), .PHASE_SIXTHS(2)) u_blue (
        .i_clk  (i_clk),
        .i_en   (pipe_en),
        .i_pix  (pix),
        .o_byte (o_rgb.blue)
    );

    // an accepted position always occupies the first stage next cycle
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pos.valid && i_pos.ready) |=> r_vld[0])
        else $error("accepted transaction did not enter the pipeline");

    // full pipeline behind a held output must refuse new input
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && !o_rgb.ready) |-> !i_pos.ready)
        else $error("input accepted while pipeline full and stalled");

    a_cfg_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_write && (t_reg_idx'(i_cfg.idx) == REG_START_SAT))
        |=> (r_cfg.start_sat == $past(i_cfg.data[LVL_W-1:0])))
        else $error("start saturation write lost");

endmodule
